[rtl/core/obl_pkg.sv]
// shared types, widths and codes for the order book level update block
`default_nettype none

package obl_pkg;

   // field widths
   localparam int unsigned PRICE_W       = 32;
   localparam int unsigned QTY_W         = 32;
   localparam int unsigned CUM_W         = 37;
   localparam int unsigned ACTION_W      = 3;
   localparam int unsigned INDEX_OUT_W   = 5;
   localparam int unsigned COUNT_OUT_W   = 6;
   localparam int unsigned DEPTH_W       = 6;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned CSR_DATA_W    = 6;

   // default book size
   localparam int unsigned LEVELS_DEFAULT = 32;

   // register reset values
   localparam logic [DEPTH_W-1:0] DEPTH_RESET     = 6'd32;
   localparam logic               ASCENDING_RESET = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_DEPTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SORT_ASCENDING = 1'd1;

   // action codes reported with every result
   localparam logic [ACTION_W-1:0] ACT_IGNORED       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVED       = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CHANGED       = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERTED      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_INSERTED_DROP = 3'd4;

   // cell load selects
   localparam logic [2:0] SEL_HOLD  = 3'd0;
   localparam logic [2:0] SEL_NEW   = 3'd1;
   localparam logic [2:0] SEL_QTY   = 3'd2;
   localparam logic [2:0] SEL_LEFT  = 3'd3;
   localparam logic [2:0] SEL_RIGHT = 3'd4;
   localparam logic [2:0] SEL_HEAD  = 3'd5;

   // one price level
   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   quantity;
   } level_type;

   // per-cell command
   typedef struct packed {
      logic [2:0] sel;
      logic       ascending;
   } cell_cmd_type;

   // per-cell compare result against the update price
   typedef struct packed {
      logic match;
      logic better;
   } cell_flags_type;

endpackage

`default_nettype wire

[rtl/core/obl_cell.sv]
// one price level cell of the book row
`default_nettype none

module obl_cell import obl_pkg::*; (
   input  wire logic           clock,
   input  wire cell_cmd_type   cmd,
   input  wire logic [PRICE_W-1:0] key_price,
   input  wire level_type      new_level,
   input  wire level_type      left_level,
   input  wire level_type      right_level,
   input  wire level_type      head_level,
   output level_type           level,
   output cell_flags_type      flags
);

   level_type level_ff;
   level_type level_in;

   // compare the update price with the held level
   always_comb begin
      flags.match  = (level_ff.price == key_price);
      flags.better = cmd.ascending ? (key_price < level_ff.price)
                                   : (key_price > level_ff.price);
   end

   // next content of the cell
   always_comb begin
      level_in = level_ff;
      case (cmd.sel)
         SEL_HOLD:  level_in = level_ff;
         SEL_NEW:   level_in = new_level;
         SEL_QTY:   level_in.quantity = new_level.quantity;
         SEL_LEFT:  level_in = left_level;
         SEL_RIGHT: level_in = right_level;
         SEL_HEAD:  level_in = head_level;
         default:   level_in = level_ff;
      endcase
   end

   // level storage
   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

`default_nettype wire

[rtl/core/order_book_level_update.sv]
// order book side: sorted price levels in a row of cells, update and cumulative readout
//
//  channel   ports                          transfer
//  request   start, busy, req_*             start high while busy low
//  result    rsp_strobe, rsp_*              every cycle rsp_strobe is high
//  config    csr_write, csr_index, csr_wdata every cycle csr_write is high
//
// an update runs a compare step across all cells, then a step that shifts the
// row into its new order, then reads out one level per cycle as the row
// rotates its head out (one result for an empty book); the level count sets the readout time.
// reset empties the book, sets depth 32 and ascending order; cell contents stay.
// results come one per cycle with no gaps; busy drops while the final result
// is shown, so the next update can start on that cycle.
`default_nettype none

module order_book_level_update import obl_pkg::*; #(
   parameter int unsigned MAX_LEVELS = LEVELS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [PRICE_W-1:0]     req_price_ticks,
   input  wire logic [QTY_W-1:0]       req_quantity,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                        rsp_strobe,
   output logic [ACTION_W-1:0]         rsp_action,
   output logic                        rsp_level_valid,
   output logic [INDEX_OUT_W-1:0]      rsp_level_index,
   output logic [PRICE_W-1:0]          rsp_level_price,
   output logic [QTY_W-1:0]            rsp_level_quantity,
   output logic [CUM_W-1:0]            rsp_cum_quantity,
   output logic [COUNT_OUT_W-1:0]      rsp_level_count,
   output logic                        rsp_last
);

   localparam int unsigned IW   = $clog2(MAX_LEVELS);
   localparam int unsigned CW   = $clog2(MAX_LEVELS + 1);
   localparam int unsigned CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic                  ascending_ff, ascending_in;
   logic [PRICE_W-1:0]    key_price_ff, key_price_in;
   logic [QTY_W-1:0]      key_qty_ff, key_qty_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ins_count_ff, ins_count_in;
   logic                  drop_ff, drop_in;
   logic [MAX_LEVELS-1:0] match_ff, match_in;
   logic [MAX_LEVELS-1:0] wall_ff, wall_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [IW-1:0]         rd_ff, rd_in;
   logic [CUM_W-1:0]      cum_ff, cum_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [ACTION_W-1:0]   rsp_action_ff, rsp_action_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [PRICE_W-1:0]    rsp_price_ff, rsp_price_in;
   logic [QTY_W-1:0]      rsp_qty_ff, rsp_qty_in;
   logic [CUM_W-1:0]      rsp_cum_ff, rsp_cum_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   level_type             levels [MAX_LEVELS];
   cell_flags_type        flags  [MAX_LEVELS];
   level_type             new_level;
   level_type             head_level;

   logic [CMPW-1:0]       depth_eff;
   logic [CMPW-1:0]       count_ext;
   logic                  book_full;
   logic                  any_match;
   logic                  qty_zero;
   logic                  op_delete;
   logic                  op_replace;
   logic                  op_insert;
   logic                  out_last;
   logic [MAX_LEVELS-1:0] del_ge;
   logic [MAX_LEVELS-1:0] wall_rev;
   logic [MAX_LEVELS-1:0] wall_low;
   logic [MAX_LEVELS-1:0] ins_ge;

   assign new_level  = '{price: key_price_ff, quantity: key_qty_ff};
   assign head_level = levels[0];
   assign busy       = (state_ff != S_IDLE);

   // effective depth and insert count after dropping the worst levels
   always_comb begin
      depth_eff = CMPW'(depth_ff);
      if (depth_eff == '0) begin
         depth_eff = CMPW'(1);
      end else if (depth_eff > CMPW'(MAX_LEVELS)) begin
         depth_eff = CMPW'(MAX_LEVELS);
      end
      count_ext    = CMPW'(count_ff);
      book_full    = (count_ext >= depth_eff);
      ins_count_in = book_full ? CW'(depth_eff - CMPW'(1)) : count_ff;
      drop_in      = book_full;
   end

   // operation decode from the registered compare flags
   assign any_match  = |match_ff;
   assign qty_zero   = (key_qty_ff == '0);
   assign op_delete  = qty_zero && any_match;
   assign op_replace = !qty_zero && any_match;
   assign op_insert  = !qty_zero && !any_match;

   // cells at or after the matching level
   assign del_ge = ~(match_ff - MAX_LEVELS'(1));

   // cells at or after the insert slot: above the last level that stays ahead
   always_comb begin
      for (int i = 0; i < int'(MAX_LEVELS); i++) begin
         wall_rev[i] = wall_ff[MAX_LEVELS-1-i];
      end
      wall_low = ~wall_rev & (wall_rev - MAX_LEVELS'(1));
      for (int i = 0; i < int'(MAX_LEVELS); i++) begin
         ins_ge[i] = wall_low[MAX_LEVELS-1-i];
      end
   end

   // row of level cells
   for (genvar k = 0; k < int'(MAX_LEVELS); k++) begin : g_cell
      logic         prev_ge;
      logic         occupied;
      logic         occupied_ins;
      logic         is_tail;
      cell_cmd_type cmd;
      level_type    left_level;
      level_type    right_level;

      assign prev_ge      = (k == 0) ? 1'b0 : ins_ge[(k == 0) ? 0 : k - 1];
      assign occupied     = (CW'(k) < count_ff);
      assign occupied_ins = (CW'(k) < ins_count_in);
      assign is_tail      = (CW'(k) + CW'(1) == count_ff);
      assign left_level   = (k == 0) ? new_level : levels[(k == 0) ? 0 : k - 1];
      assign right_level  = (k == int'(MAX_LEVELS) - 1) ? head_level
                          : levels[(k == int'(MAX_LEVELS) - 1) ? k : k + 1];

      // compare flags masked to the live part of the book
      assign match_in[k] = flags[k].match && occupied;
      assign wall_in[k]  = !flags[k].better && occupied_ins;

      // cell command
      always_comb begin
         cmd.ascending = ascending_ff;
         cmd.sel       = SEL_HOLD;
         case (state_ff)
            S_UPD: begin
               if (op_delete) begin
                  cmd.sel = del_ge[k] ? SEL_RIGHT : SEL_HOLD;
               end else if (op_replace) begin
                  cmd.sel = match_ff[k] ? SEL_QTY : SEL_HOLD;
               end else if (op_insert) begin
                  if (ins_ge[k] && !prev_ge) begin
                     cmd.sel = SEL_NEW;
                  end else if (prev_ge && (CW'(k) <= ins_count_ff)) begin
                     cmd.sel = SEL_LEFT;
                  end
               end
            end
            S_OUT: begin
               if (count_ff != '0) begin
                  cmd.sel = is_tail ? SEL_HEAD : SEL_RIGHT;
               end
            end
            default: cmd.sel = SEL_HOLD;
         endcase
      end

      obl_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .key_price   (key_price_ff),
         .new_level   (new_level),
         .left_level  (left_level),
         .right_level (right_level),
         .head_level  (head_level),
         .level       (levels[k]),
         .flags       (flags[k])
      );
   end

   assign out_last = (CW'(rd_ff) + CW'(1) == count_ff);

   // sequencer, book count and readout
   always_comb begin
      state_in      = state_ff;
      key_price_in  = key_price_ff;
      key_qty_in    = key_qty_ff;
      count_in      = count_ff;
      action_in     = action_ff;
      rd_in         = rd_ff;
      cum_in        = cum_ff;
      rsp_strobe_in = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_cum_in    = rsp_cum_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_price_in = req_price_ticks;
               key_qty_in   = req_quantity;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (op_delete) begin
               action_in = ACT_REMOVED;
               count_in  = count_ff - CW'(1);
            end else if (op_replace) begin
               action_in = ACT_CHANGED;
            end else if (op_insert) begin
               action_in = drop_ff ? ACT_INSERTED_DROP : ACT_INSERTED;
               count_in  = ins_count_ff + CW'(1);
            end else begin
               action_in = ACT_IGNORED;
            end
            rd_in    = '0;
            cum_in   = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_action_in = action_ff;
            rsp_count_in  = COUNT_OUT_W'(count_ff);
            if (count_ff == '0) begin
               rsp_valid_in = 1'b0;
               rsp_index_in = '0;
               rsp_price_in = '0;
               rsp_qty_in   = '0;
               rsp_cum_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cum_in       = cum_ff + CUM_W'(head_level.quantity);
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_OUT_W'(rd_ff);
               rsp_price_in = head_level.price;
               rsp_qty_in   = head_level.quantity;
               rsp_cum_in   = cum_in;
               rsp_last_in  = out_last;
               rd_in        = rd_ff + IW'(1);
               if (out_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration writes
   always_comb begin
      depth_in     = depth_ff;
      ascending_in = ascending_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ACTIVE_DEPTH:   depth_in     = csr_wdata[DEPTH_W-1:0];
            REG_SORT_ASCENDING: ascending_in = csr_wdata[0];
            default: begin
               depth_in     = depth_ff;
               ascending_in = ascending_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         depth_ff      <= DEPTH_RESET;
         ascending_ff  <= ASCENDING_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         depth_ff      <= depth_in;
         ascending_ff  <= ascending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_price_ff  <= key_price_in;
      key_qty_ff    <= key_qty_in;
      ins_count_ff  <= ins_count_in;
      drop_ff       <= drop_in;
      match_ff      <= match_in;
      wall_ff       <= wall_in;
      action_ff     <= action_in;
      rd_ff         <= rd_in;
      cum_ff        <= cum_in;
      rsp_action_ff <= rsp_action_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_cum_ff    <= rsp_cum_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_level_valid    = rsp_valid_ff;
   assign rsp_level_index    = rsp_index_ff;
   assign rsp_level_price    = rsp_price_ff;
   assign rsp_level_quantity = rsp_qty_ff;
   assign rsp_cum_quantity   = rsp_cum_ff;
   assign rsp_level_count    = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   // prices in the book are unique, so at most one cell matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> $onehot0(match_ff))
      else $error("more than one level matched the update price");

   // the book never holds more levels than the row has cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEVELS))
      else $error("level count beyond row length");

   // an empty book gives a single final result
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_level_valid) |-> (rsp_last && (rsp_level_count == '0)))
      else $error("empty book result malformed");

   // no result transfer directly follows the final result
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result transfer right after final result");

endmodule

`default_nettype wire
